// ===== rtl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared constants, operation codes, command and status types and helpers.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 8;
	localparam int TAB_CELLS    = 4;
	localparam int MAX_SCALE    = 16;

	localparam int SCALE_W  = 5;
	localparam int CW_W     = $clog2(GLYPH_WIDTH * MAX_SCALE + 1);
	localparam int CH_W     = $clog2(GLYPH_HEIGHT * MAX_SCALE + 1);
	localparam int TAB_UNIT = GLYPH_WIDTH * TAB_CELLS;
	localparam int PER_W    = $clog2(TAB_UNIT * MAX_SCALE + 1);
	localparam int TABN_W   = $clog2(TAB_CELLS + 1);
	localparam int CFG_W    = 13;
	localparam int POS_W    = 16;

	// Input actions.
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_BS    = 2'd1;
	localparam logic [1:0] ACT_SHOW  = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Output commands.
	localparam logic [1:0] CMD_DRAW   = 2'd0;
	localparam logic [1:0] CMD_SCROLL = 2'd1;
	localparam logic [1:0] CMD_FILL   = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_BAR   = 8'd124;

	// Configuration register indexes.
	localparam logic [1:0] IDX_WIDTH  = 2'd0;
	localparam logic [1:0] IDX_HEIGHT = 2'd1;
	localparam logic [1:0] IDX_SCALE  = 2'd2;

	// Datapath operations.
	localparam logic [2:0] DP_NONE = 3'd0;
	localparam logic [2:0] DP_BRK  = 3'd1;
	localparam logic [2:0] DP_SCR  = 3'd2;
	localparam logic [2:0] DP_DRAW = 3'd3;
	localparam logic [2:0] DP_RET  = 3'd4;
	localparam logic [2:0] DP_FILL = 3'd5;
	localparam logic [2:0] DP_MOD  = 3'd6;
	localparam logic [2:0] DP_FIN  = 3'd7;

	// Glyph selects for a draw.
	localparam logic [1:0] G_CODE  = 2'd0;
	localparam logic [1:0] G_SPACE = 2'd1;
	localparam logic [1:0] G_BAR   = 2'd2;

	typedef struct packed {
		logic       load;
		logic [2:0] op;
		logic [1:0] gsel;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic out_free;
		logic mod_busy;
		logic mod_zero;
	} sts_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [6:0]       glyph_code;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [7:0]       scroll_pixels;
	} res_t;

	function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] v);
		logic [SCALE_W-1:0] r;
		if (v == '0) begin
			r = SCALE_W'(1);
		end else if (v > SCALE_W'(MAX_SCALE)) begin
			r = SCALE_W'(MAX_SCALE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [7:0] sat8(input logic [CH_W-1:0] v);
		logic [15:0] w;
		w = 16'(v);
		return (w > 16'd255) ? 8'hFF : w[7:0];
	endfunction

endpackage

// ===== rtl/tcc_if.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine channel interfaces
// Input, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;

	modport source (output valid, action, char_code, input ready);
	modport sink (input valid, action, char_code, output ready);
endinterface

interface tcc_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [6:0]                glyph_code;
	logic [tcc_pkg::POS_W-1:0] pos_x;
	logic [tcc_pkg::POS_W-1:0] pos_y;
	logic [7:0]                scroll_pixels;
	logic                      last;

	modport source (output valid, command, glyph_code, pos_x, pos_y, scroll_pixels, last,
		input ready);
	modport sink (input valid, command, glyph_code, pos_x, pos_y, scroll_pixels, last,
		output ready);
endinterface

interface tcc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                index;
	logic [tcc_pkg::CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine
// Turns console transactions into draw, scroll and fill command transactions.
// ----------------------------------------------------------------------------
// One transaction at a time: input is taken again only once the sequencer is back in idle.
// A line wrap adds a break and a scroll step; clear is one fill step, show cursor a bar and a step back.
// A tab draws spaces until the remainder unit finds the cursor x on a tab stop, at most 4 spaces.
// A stalled result side holds the sequencer at every draw, scroll, fill and finish step.
// Reset returns the cursor to 0,0, the line advance to one glyph height and registers to default.
module text_console_cursor_engine (
	input  logic       clk,
	input  logic       arst_n,
	tcc_in_if.sink     in_ch,
	tcc_out_if.source  out_ch,
	tcc_cfg_if.sink    cfg_ch
);

	tcc_pkg::cmd_t cmd;
	tcc_pkg::sts_t sts;

	tcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.sts    (sts),
		.cmd    (cmd)
	);

	tcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (in_ch.char_code),
		.cmd       (cmd),
		.sts       (sts),
		.out_ch    (out_ch),
		.cfg_ch    (cfg_ch)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input taken again right after a transaction");

	a_no_op_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != tcc_pkg::DP_NONE) |-> !in_ch.ready)
		else $error("datapath step issued while input is open");

	a_tab_wait_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mod_busy |-> !in_ch.ready)
		else $error("tab stop search running while input is open");

endmodule

// ===== rtl/tcc_rem.sv =====
// ----------------------------------------------------------------------------
// Tab stop remainder unit
// Restoring remainder of the cursor x by the tab period, one bit per cycle.
// ----------------------------------------------------------------------------
module tcc_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tcc_pkg::POS_W-1:0]  dividend,
	input  logic [tcc_pkg::PER_W-1:0]  divisor,
	output logic                       busy,
	output logic                       zero
);

	localparam int CNT_W = $clog2(tcc_pkg::POS_W + 1);

	logic [CNT_W-1:0]          cnt_q;
	logic [tcc_pkg::PER_W-1:0] rem_q;
	logic [tcc_pkg::POS_W-1:0] sh_q;
	logic [tcc_pkg::PER_W:0]   trial;
	logic [tcc_pkg::PER_W:0]   trial_sub;

	always_comb begin
		trial = {rem_q, sh_q[tcc_pkg::POS_W-1]};
		if (trial >= {1'b0, divisor}) begin
			trial_sub = trial - {1'b0, divisor};
		end else begin
			trial_sub = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(tcc_pkg::POS_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= trial_sub[tcc_pkg::PER_W-1:0];
			sh_q  <= {sh_q[tcc_pkg::POS_W-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign zero = (rem_q == '0);

endmodule

// ===== rtl/tcc_dp.sv =====
// ----------------------------------------------------------------------------
// Cursor datapath
// Configuration registers, cursor state, result lookahead and output register.
// ----------------------------------------------------------------------------
module tcc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           char_code,
	input  tcc_pkg::cmd_t        cmd,
	output tcc_pkg::sts_t        sts,
	tcc_out_if.source            out_ch,
	tcc_cfg_if.sink              cfg_ch
);

	logic [tcc_pkg::CFG_W-1:0]   win_w_q;
	logic [tcc_pkg::CFG_W-1:0]   win_h_q;
	logic [tcc_pkg::SCALE_W-1:0] scale_q;
	logic [tcc_pkg::POS_W-1:0]   cx_q;
	logic [tcc_pkg::POS_W-1:0]   cy_q;
	logic [7:0]                  adv_q;
	logic [7:0]                  code_q;
	logic                        pend_vld_q;
	tcc_pkg::res_t               pend_q;
	logic                        out_vld_q;
	tcc_pkg::res_t               out_q;
	logic                        out_last_q;

	logic [tcc_pkg::CW_W-1:0]    cw;
	logic [tcc_pkg::CH_W-1:0]    ch;
	logic [tcc_pkg::PER_W-1:0]   period;
	logic [tcc_pkg::SCALE_W-1:0] new_scale;
	logic [tcc_pkg::CH_W-1:0]    new_ch;
	logic [7:0]                  glyph;
	logic                        out_free;
	logic                        emit;
	logic                        move;
	tcc_pkg::res_t               new_res;
	logic [tcc_pkg::POS_W-1:0]   cx_d;
	logic [tcc_pkg::POS_W-1:0]   cy_d;
	logic [7:0]                  adv_d;
	logic                        cfg_hit;
	logic                        mod_busy;
	logic                        mod_zero;

	assign cw        = tcc_pkg::CW_W'(int'(scale_q) * tcc_pkg::GLYPH_WIDTH);
	assign ch        = tcc_pkg::CH_W'(int'(scale_q) * tcc_pkg::GLYPH_HEIGHT);
	assign period    = tcc_pkg::PER_W'(int'(scale_q) * tcc_pkg::TAB_UNIT);
	assign new_scale = tcc_pkg::eff_scale(cfg_ch.data[tcc_pkg::SCALE_W-1:0]);
	assign new_ch    = tcc_pkg::CH_W'(int'(new_scale) * tcc_pkg::GLYPH_HEIGHT);
	assign cfg_hit   = cfg_ch.valid && cfg_ch.ready;
	assign out_free  = !out_vld_q || out_ch.ready;

	always_comb begin
		unique case (cmd.gsel)
			tcc_pkg::G_SPACE: glyph = tcc_pkg::CH_SPACE;
			tcc_pkg::G_BAR:   glyph = tcc_pkg::CH_BAR;
			default:          glyph = code_q;
		endcase
	end

	always_comb begin
		cx_d    = cx_q;
		cy_d    = cy_q;
		adv_d   = adv_q;
		emit    = 1'b0;
		new_res = '0;
		case (cmd.op)
			tcc_pkg::DP_BRK: begin
				cy_d  = cy_q + tcc_pkg::POS_W'(adv_q);
				cx_d  = '0;
				adv_d = tcc_pkg::sat8(ch);
			end
			tcc_pkg::DP_SCR: begin
				if ((17'(cy_q) + 17'(ch)) > 17'(win_h_q)) begin
					emit                  = 1'b1;
					new_res.command       = tcc_pkg::CMD_SCROLL;
					new_res.scroll_pixels = 8'(ch);
					cy_d                  = cy_q - tcc_pkg::POS_W'(ch);
				end
			end
			tcc_pkg::DP_DRAW: begin
				if (!glyph[7]) begin
					emit               = 1'b1;
					new_res.command    = tcc_pkg::CMD_DRAW;
					new_res.glyph_code = glyph[6:0];
					new_res.pos_x      = cx_q;
					new_res.pos_y      = cy_q;
				end
				cx_d = cx_q + tcc_pkg::POS_W'(cw);
			end
			tcc_pkg::DP_RET: begin
				if (cx_q == '0) begin
					cx_d = tcc_pkg::POS_W'(win_w_q) - tcc_pkg::POS_W'(cw);
					cy_d = cy_q - tcc_pkg::POS_W'(ch);
				end else begin
					cx_d = cx_q - tcc_pkg::POS_W'(cw);
				end
			end
			tcc_pkg::DP_FILL: begin
				emit            = 1'b1;
				new_res.command = tcc_pkg::CMD_FILL;
				cx_d            = '0;
				cy_d            = '0;
			end
			default: begin
			end
		endcase
		if (cfg_hit && (cfg_ch.index == tcc_pkg::IDX_SCALE) &&
			(16'(new_ch) > 16'(adv_q))) begin
			adv_d = tcc_pkg::sat8(new_ch);
		end
	end

	assign move = pend_vld_q && (emit || (cmd.op == tcc_pkg::DP_FIN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q    <= tcc_pkg::CFG_W'(1024);
			win_h_q    <= tcc_pkg::CFG_W'(768);
			scale_q    <= tcc_pkg::SCALE_W'(1);
			cx_q       <= '0;
			cy_q       <= '0;
			adv_q      <= tcc_pkg::sat8(tcc_pkg::CH_W'(tcc_pkg::GLYPH_HEIGHT));
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			cx_q  <= cx_d;
			cy_q  <= cy_d;
			adv_q <= adv_d;
			if (cfg_hit) begin
				unique case (cfg_ch.index)
					tcc_pkg::IDX_WIDTH:  win_w_q <= cfg_ch.data;
					tcc_pkg::IDX_HEIGHT: win_h_q <= cfg_ch.data;
					tcc_pkg::IDX_SCALE:  scale_q <= new_scale;
					default: begin
					end
				endcase
			end
			if (emit) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.op == tcc_pkg::DP_FIN) begin
				pend_vld_q <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= char_code;
		end
		if (emit) begin
			pend_q <= new_res;
		end
		if (move) begin
			out_q      <= pend_q;
			out_last_q <= (cmd.op == tcc_pkg::DP_FIN);
		end
	end

	tcc_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == tcc_pkg::DP_MOD),
		.dividend (cx_q),
		.divisor  (period),
		.busy     (mod_busy),
		.zero     (mod_zero)
	);

	assign sts.wrap     = (17'(cx_q) + 17'(cw)) > 17'(win_w_q);
	assign sts.out_free = out_free;
	assign sts.mod_busy = mod_busy;
	assign sts.mod_zero = mod_zero;

	assign cfg_ch.ready         = 1'b1;
	assign out_ch.valid         = out_vld_q;
	assign out_ch.command       = out_q.command;
	assign out_ch.glyph_code    = out_q.glyph_code;
	assign out_ch.pos_x         = out_q.pos_x;
	assign out_ch.pos_y         = out_q.pos_y;
	assign out_ch.scroll_pixels = out_q.scroll_pixels;
	assign out_ch.last          = out_last_q;

endmodule

// ===== rtl/tcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cursor controller
// Sequences each console transaction into datapath steps and waits on output.
// ----------------------------------------------------------------------------
module tcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	tcc_in_if.sink        in_ch,
	input  tcc_pkg::sts_t sts,
	output tcc_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FETCH = 4'd1;
	localparam logic [3:0] S_TEST  = 4'd2;
	localparam logic [3:0] S_BRK   = 4'd3;
	localparam logic [3:0] S_SCR   = 4'd4;
	localparam logic [3:0] S_DRAW  = 4'd5;
	localparam logic [3:0] S_RET   = 4'd6;
	localparam logic [3:0] S_FILL  = 4'd7;
	localparam logic [3:0] S_MODS  = 4'd8;
	localparam logic [3:0] S_MODW  = 4'd9;
	localparam logic [3:0] S_FIN   = 4'd10;

	localparam logic [2:0] SEQ_PUT   = 3'd0;
	localparam logic [2:0] SEQ_NL    = 3'd1;
	localparam logic [2:0] SEQ_TAB   = 3'd2;
	localparam logic [2:0] SEQ_BS    = 3'd3;
	localparam logic [2:0] SEQ_SHOW  = 3'd4;
	localparam logic [2:0] SEQ_CLEAR = 3'd5;

	localparam logic [2:0] M_SPACE = 3'd0;
	localparam logic [2:0] M_BAR   = 3'd1;
	localparam logic [2:0] M_CODE  = 3'd2;
	localparam logic [2:0] M_RET   = 3'd3;
	localparam logic [2:0] M_LB    = 3'd4;
	localparam logic [2:0] M_TAB   = 3'd5;
	localparam logic [2:0] M_FILL  = 3'd6;
	localparam logic [2:0] M_END   = 3'd7;

	function automatic logic [2:0] macro_at(input logic [2:0] seq, input logic [2:0] step);
		logic [2:0] m;
		m = M_END;
		case (seq)
			SEQ_PUT: begin
				if (step == 3'd0) m = M_CODE;
			end
			SEQ_NL: begin
				case (step)
					3'd0:    m = M_SPACE;
					3'd1:    m = M_RET;
					3'd2:    m = M_LB;
					default: m = M_END;
				endcase
			end
			SEQ_TAB: begin
				case (step)
					3'd0:    m = M_SPACE;
					3'd1:    m = M_TAB;
					default: m = M_END;
				endcase
			end
			SEQ_BS: begin
				case (step)
					3'd0:              m = M_SPACE;
					3'd1, 3'd2, 3'd4:  m = M_RET;
					3'd3:              m = M_BAR;
					default:           m = M_END;
				endcase
			end
			SEQ_SHOW: begin
				case (step)
					3'd0:    m = M_BAR;
					3'd1:    m = M_RET;
					default: m = M_END;
				endcase
			end
			SEQ_CLEAR: begin
				if (step == 3'd0) m = M_FILL;
			end
			default: m = M_END;
		endcase
		return m;
	endfunction

	logic [3:0]                 state_q;
	logic [3:0]                 state_d;
	logic [2:0]                 seq_q;
	logic [2:0]                 seq_d;
	logic [2:0]                 step_q;
	logic [2:0]                 step_d;
	logic [1:0]                 gsel_q;
	logic [1:0]                 gsel_d;
	logic                       brk_put_q;
	logic                       brk_put_d;
	logic [tcc_pkg::TABN_W-1:0] tab_n_q;
	logic [tcc_pkg::TABN_W-1:0] tab_n_d;
	logic [2:0]                 macro;
	logic [2:0]                 seq_in;

	assign macro = macro_at(seq_q, step_q);

	always_comb begin
		unique case (in_ch.action)
			tcc_pkg::ACT_PUT: begin
				if (in_ch.char_code == tcc_pkg::CH_NL) begin
					seq_in = SEQ_NL;
				end else if (in_ch.char_code == tcc_pkg::CH_TAB) begin
					seq_in = SEQ_TAB;
				end else begin
					seq_in = SEQ_PUT;
				end
			end
			tcc_pkg::ACT_BS:   seq_in = SEQ_BS;
			tcc_pkg::ACT_SHOW: seq_in = SEQ_SHOW;
			default:           seq_in = SEQ_CLEAR;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		seq_d       = seq_q;
		step_d      = step_q;
		gsel_d      = gsel_q;
		brk_put_d   = brk_put_q;
		tab_n_d     = tab_n_q;
		cmd.load    = 1'b0;
		cmd.op      = tcc_pkg::DP_NONE;
		cmd.gsel    = gsel_q;
		in_ch.ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					cmd.load = 1'b1;
					seq_d    = seq_in;
					step_d   = '0;
					tab_n_d  = '0;
					state_d  = S_FETCH;
				end
			end
			S_FETCH: begin
				step_d = step_q + 3'd1;
				case (macro)
					M_SPACE: begin
						gsel_d  = tcc_pkg::G_SPACE;
						state_d = S_TEST;
					end
					M_BAR: begin
						gsel_d  = tcc_pkg::G_BAR;
						state_d = S_TEST;
					end
					M_CODE: begin
						gsel_d  = tcc_pkg::G_CODE;
						state_d = S_TEST;
					end
					M_RET:  state_d = S_RET;
					M_LB: begin
						brk_put_d = 1'b0;
						state_d   = S_BRK;
					end
					M_TAB:  state_d = S_MODS;
					M_FILL: state_d = S_FILL;
					default: begin
						step_d  = step_q;
						state_d = S_FIN;
					end
				endcase
			end
			S_TEST: begin
				if (sts.wrap) begin
					brk_put_d = 1'b1;
					state_d   = S_BRK;
				end else begin
					state_d = S_DRAW;
				end
			end
			S_BRK: begin
				cmd.op  = tcc_pkg::DP_BRK;
				state_d = S_SCR;
			end
			S_SCR: begin
				if (sts.out_free) begin
					cmd.op  = tcc_pkg::DP_SCR;
					state_d = brk_put_q ? S_DRAW : S_FETCH;
				end
			end
			S_DRAW: begin
				if (sts.out_free) begin
					cmd.op  = tcc_pkg::DP_DRAW;
					state_d = S_FETCH;
				end
			end
			S_RET: begin
				cmd.op  = tcc_pkg::DP_RET;
				state_d = S_FETCH;
			end
			S_FILL: begin
				if (sts.out_free) begin
					cmd.op  = tcc_pkg::DP_FILL;
					state_d = S_FETCH;
				end
			end
			S_MODS: begin
				cmd.op  = tcc_pkg::DP_MOD;
				tab_n_d = tab_n_q + tcc_pkg::TABN_W'(1);
				state_d = S_MODW;
			end
			S_MODW: begin
				if (!sts.mod_busy) begin
					if (!sts.mod_zero && (tab_n_q < tcc_pkg::TABN_W'(tcc_pkg::TAB_CELLS))) begin
						step_d  = '0;
						state_d = S_FETCH;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.op  = tcc_pkg::DP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			seq_q     <= SEQ_PUT;
			step_q    <= '0;
			gsel_q    <= tcc_pkg::G_CODE;
			brk_put_q <= 1'b0;
			tab_n_q   <= '0;
		end else begin
			state_q   <= state_d;
			seq_q     <= seq_d;
			step_q    <= step_d;
			gsel_q    <= gsel_d;
			brk_put_q <= brk_put_d;
			tab_n_q   <= tab_n_d;
		end
	end

endmodule

// ===== tb/sv/text_console_cursor_engine_tb.sv =====
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives console transactions and register writes into the engine. A
// scoreboard class tracks its own cursor, line advance and window settings,
// predicts the draw, scroll and fill commands of every accepted transaction
// and checks each result transaction against them in order. The sender works
// in bursts and the result side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
	import tcc_pkg::*;

	localparam int MAX_RESULTS       = 8;
	localparam int FIRST_SILENT_CODE = 128;
	localparam int IDLE_LIMIT        = 5000;
	localparam int SETTLE_CYCLES     = 64;
	localparam int RANDOM_PHASES     = 8;
	localparam int ITEMS_PER_PHASE   = 50;
	localparam int MAX_PRINTED       = 50;

	typedef struct packed {
		res_t body;
		logic last;
	} console_cmd_t;

	class console_board;
		logic [12:0]  win_w;
		logic [12:0]  win_h;
		logic [4:0]   scale;
		logic [15:0]  cur_x;
		logic [15:0]  cur_y;
		logic [7:0]   line_adv;
		console_cmd_t expected_cmds[$];
		console_cmd_t item_cmds[$];
		int           errors;
		int           results_seen;
		int           inputs_seen;
		int           writes_seen;

		function new();
			win_w = 13'd1024;
			win_h = 13'd768;
			scale = 5'd1;
			cur_x = '0;
			cur_y = '0;
			line_adv = 8'(GLYPH_HEIGHT);
			errors = 0;
			results_seen = 0;
			inputs_seen = 0;
			writes_seen = 0;
		endfunction

		function int unsigned scale_eff();
			if (scale == 0) return 1;
			if (scale > MAX_SCALE) return MAX_SCALE;
			return scale;
		endfunction

		function int unsigned cell_w();
			return GLYPH_WIDTH * scale_eff();
		endfunction

		function int unsigned cell_h();
			return GLYPH_HEIGHT * scale_eff();
		endfunction

		function void add_cmd(logic [1:0] cmd, logic [7:0] glyph, logic [15:0] x,
			logic [15:0] y, int unsigned rows);
			console_cmd_t c;
			if (item_cmds.size() >= MAX_RESULTS) return;
			c.body.command = cmd;
			c.body.glyph_code = glyph[6:0];
			c.body.pos_x = x;
			c.body.pos_y = y;
			c.body.scroll_pixels = rows[7:0];
			c.last = 1'b0;
			item_cmds.push_back(c);
		endfunction

		function void new_line();
			int unsigned ch;
			ch = cell_h();
			cur_y = 16'(cur_y + line_adv);
			cur_x = '0;
			line_adv = (ch > 255) ? 8'hFF : ch[7:0];
			if (cur_y + ch > win_h) begin
				add_cmd(CMD_SCROLL, 8'd0, 16'd0, 16'd0, ch);
				cur_y = 16'(cur_y - ch);
			end
		endfunction

		function void put_plain(logic [7:0] code);
			int unsigned cw;
			cw = cell_w();
			if (cur_x + cw > win_w) new_line();
			if (code < FIRST_SILENT_CODE) add_cmd(CMD_DRAW, code, cur_x, cur_y, 0);
			cur_x = 16'(cur_x + cw);
		endfunction

		function void retract();
			if (cur_x == 0) begin
				cur_x = 16'(win_w);
				cur_y = 16'(cur_y - cell_h());
			end
			cur_x = 16'(cur_x - cell_w());
		endfunction

		function void put_char(logic [7:0] code);
			int unsigned tab_period;
			int n;
			if (code == CH_NL) begin
				put_plain(CH_SPACE);
				retract();
				new_line();
			end else if (code == CH_TAB) begin
				tab_period = TAB_CELLS * cell_w();
				put_plain(CH_SPACE);
				n = 1;
				while ((cur_x % tab_period) != 0 && n < TAB_CELLS) begin
					put_plain(CH_SPACE);
					n++;
				end
			end else begin
				put_plain(code);
			end
		endfunction

		function void note_input(logic [1:0] act, logic [7:0] code);
			item_cmds.delete();
			case (act)
				ACT_PUT: put_char(code);
				ACT_BS: begin
					put_plain(CH_SPACE);
					retract();
					retract();
					put_plain(CH_BAR);
					retract();
				end
				ACT_SHOW: begin
					put_plain(CH_BAR);
					retract();
				end
				default: begin
					add_cmd(CMD_FILL, 8'd0, 16'd0, 16'd0, 0);
					cur_x = '0;
					cur_y = '0;
				end
			endcase
			if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
			foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
			inputs_seen++;
		endfunction

		function void write_reg(logic [1:0] idx, logic [12:0] value);
			int unsigned ch;
			case (idx)
				IDX_WIDTH: win_w = value;
				IDX_HEIGHT: win_h = value;
				IDX_SCALE: begin
					scale = value[4:0];
					ch = cell_h();
					if (ch > line_adv) line_adv = (ch > 255) ? 8'hFF : ch[7:0];
				end
				default: ;
			endcase
			writes_seen++;
		endfunction

		task report(string msg);
			errors++;
			// Keep the log bounded when the block is badly broken.
			if (errors <= MAX_PRINTED) $display("MISMATCH: %s", msg);
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name,
					got, want));
		endtask

		task check_result(console_cmd_t got);
			console_cmd_t want;
			results_seen++;
			if (expected_cmds.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected, command %0d",
					results_seen, got.body.command));
				return;
			end
			want = expected_cmds.pop_front();
			check_field("command", got.body.command, want.body.command);
			check_field("glyph_code", got.body.glyph_code, want.body.glyph_code);
			check_field("pos_x", got.body.pos_x, want.body.pos_x);
			check_field("pos_y", got.body.pos_y, want.body.pos_y);
			check_field("scroll_pixels", got.body.scroll_pixels, want.body.scroll_pixels);
			check_field("last", got.last, want.last);
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   burst_left;

	tcc_in_if  in_ch();
	tcc_out_if out_ch();
	tcc_cfg_if cfg_ch();

	console_board board = new();

	text_console_cursor_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_item(logic [1:0] act, logic [7:0] code);
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.char_code <= code;
		@(posedge clk);
		while (in_ch.ready !== 1'b1) @(posedge clk);
		board.note_input(act, code);
		burst_left--;
		if (burst_left <= 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic send_random_item();
		logic [1:0] act;
		logic [7:0] code;
		code = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 19))
			12, 13, 14: act = ACT_BS;
			15, 16, 17: act = ACT_SHOW;
			18, 19: act = ACT_CLEAR;
			default: begin
				act = ACT_PUT;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: code = 8'($urandom_range(32, 126));
					5: code = CH_NL;
					6: code = CH_TAB;
					7: code = 8'($urandom_range(FIRST_SILENT_CODE, 255));
					default: ;
				endcase
			end
		endcase
		send_item(act, code);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		board.write_reg(idx, value);
	endtask

	task automatic write_config(logic [12:0] w, logic [12:0] h, logic [12:0] s);
		write_reg(IDX_WIDTH, w);
		write_reg(IDX_HEIGHT, h);
		write_reg(IDX_SCALE, s);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (board.expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [12:0] pick_width();
		case ($urandom_range(0, 5))
			0: return 13'd8;
			1: return 13'd4096;
			2: return 13'h1FFF;
			3: return 13'($urandom_range(8, 64));
			4: return 13'($urandom_range(8, 4096));
			default: return 13'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic [12:0] pick_height();
		case ($urandom_range(0, 5))
			0: return 13'd8;
			1: return 13'd4096;
			2: return 13'h1FFF;
			3, 4: return 13'($urandom_range(8, 128));
			default: return 13'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic [12:0] pick_scale();
		case ($urandom_range(0, 7))
			0: return 13'd0;
			1: return 13'd16;
			2: return 13'd31;
			3: return 13'($urandom_range(0, 8191));
			default: return 13'($urandom_range(1, 4));
		endcase
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_PUT;
		in_ch.char_code = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = IDX_WIDTH;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		burst_left = $urandom_range(1, 8);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ACT_PUT, 8'd65);
		send_item(ACT_PUT, 8'd0);
		send_item(ACT_PUT, 8'd127);
		send_item(ACT_PUT, 8'd128);
		send_item(ACT_PUT, 8'd255);
		send_item(ACT_PUT, 8'hAA);
		send_item(ACT_PUT, 8'h55);
		send_item(ACT_PUT, CH_TAB);
		send_item(ACT_PUT, CH_TAB);
		send_item(ACT_PUT, CH_NL);
		send_item(ACT_BS, 8'd0);
		send_item(ACT_SHOW, 8'hFF);
		send_item(ACT_CLEAR, 8'd0);
		send_item(ACT_BS, 8'd0);
		send_item(ACT_SHOW, 8'd0);
		in_ch.valid <= 1'b0;
		settle();

		write_config(13'd20, 13'd8, 13'd0);
		send_item(ACT_PUT, 8'd97);
		send_item(ACT_PUT, 8'd98);
		send_item(ACT_PUT, 8'd99);
		send_item(ACT_PUT, CH_TAB);
		send_item(ACT_PUT, CH_NL);
		send_item(ACT_BS, 8'd0);
		in_ch.valid <= 1'b0;
		settle();

		write_config(13'h1FFF, 13'h1FFF, 13'd31);
		send_item(ACT_PUT, 8'd90);
		send_item(ACT_PUT, CH_TAB);
		send_item(ACT_PUT, CH_NL);
		send_item(ACT_CLEAR, 8'd0);
		in_ch.valid <= 1'b0;
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_config(pick_width(), pick_height(), pick_scale());
			repeat (ITEMS_PER_PHASE) send_random_item();
			in_ch.valid <= 1'b0;
			settle();
		end

		$display("Sent %0d console transactions, checked %0d result transactions,",
			board.inputs_seen, board.results_seen);
		$display("across %0d register writes sweeping window size and font scale extremes.",
			board.writes_seen);
		if (board.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		console_cmd_t got;
		int rx_cycle;
		int stall_mode;
		out_ch.ready = 1'b0;
		rx_cycle = 0;
		stall_mode = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.body.command = out_ch.command;
				got.body.glyph_code = out_ch.glyph_code;
				got.body.pos_x = out_ch.pos_x;
				got.body.pos_y = out_ch.pos_y;
				got.body.scroll_pixels = out_ch.scroll_pixels;
				got.last = out_ch.last;
				board.check_result(got);
			end
			rx_cycle++;
			if (rx_cycle % 40 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= rx_cycle[2];
			endcase
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
				|| (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Timeout: no transaction for %0d cycles.", IDLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== text_console_cursor_engine.f =====
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_rem.sv
rtl/tcc_dp.sv
rtl/tcc_ctrl.sv
rtl/text_console_cursor_engine.sv
tb/sv/text_console_cursor_engine_tb.sv
